[sv/bcc_pkg.sv]
// shared types, constants and codes of the barrier completion tracker
package bcc_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_TYPES   = 8;
   localparam int MAX_RESULTS = 16;

   localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int RETIRE_W   = $clog2(MAX_RESULTS);
   localparam int TYPE_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

   typedef enum logic [1:0] {
      FUNC_REQUEST = 2'd0,
      FUNC_ACK     = 2'd1,
      FUNC_FLUSH   = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STAT_QUEUED    = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_RETIRED   = 3'd2,
      STAT_NONE      = 3'd3,
      STAT_FLUSHED   = 3'd4,
      STAT_FULL      = 3'd5,
      STAT_BAD_TYPE  = 3'd6
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RETIRE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  type_id;
      logic [63:0] app_seqno;
      logic [63:0] ack_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  type_out;
      logic [63:0] seqno_out;
      logic [63:0] barrier_tag;
      logic        last;
   } rsp_type;

   typedef logic [3:0] csr_type;

   typedef struct packed {
      logic [2:0]  type_id;
      logic [63:0] seqno;
      logic [63:0] tag;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } queue_ctl_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

[sv/bcc_intf.sv]
// valid/ready channels of the tracker: request, response and register write
interface bcc_req_if;
   import bcc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bcc_rsp_if;
   import bcc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface bcc_csr_if;
   import bcc_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/bcc_cell.sv]
// one queue slot: holds an entry, loads a new one or takes its neighbor's
module bcc_cell (
   input  logic                  clock,
   input  bcc_pkg::cell_ctl_type ctl,
   input  bcc_pkg::entry_type    push_entry,
   input  bcc_pkg::entry_type    next_entry,
   output bcc_pkg::entry_type    entry
);
   import bcc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // load wins; push and pop never meet in one cycle
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = push_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[sv/bcc_queue.sv]
// in-order pending queue built as a shifting row of cells, head in cell 0
module bcc_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  bcc_pkg::queue_ctl_type            ctl,
   input  bcc_pkg::entry_type                push_entry,
   output bcc_pkg::entry_type                head,
   output bcc_pkg::entry_type                second,
   output logic [bcc_pkg::COUNT_W-1:0]       count
);
   import bcc_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   entry_type          chain [QUEUE_DEPTH];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (ctl.flush) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of cells, each shifting toward the head on a pop
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctl_type cctl;
      entry_type    nbr;
      assign cctl.load  = ctl.push && (count_ff == COUNT_W'(i));
      assign cctl.shift = ctl.pop;
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = chain[i+1];
      end
      bcc_cell u_cell (
         .clock      (clock),
         .ctl        (cctl),
         .push_entry (push_entry),
         .next_entry (nbr),
         .entry      (chain[i])
      );
   end

   assign head   = chain[0];
   assign second = chain[1];
   assign count  = count_ff;

`ifndef SYNTHESIS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (count_ff < COUNT_W'(QUEUE_DEPTH)))
      else $error("push into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> (count_ff != '0))
      else $error("pop from an empty queue");
   a_push_pop_apart: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.pop))
      else $error("push and pop in the same cycle");
`endif

endmodule

[sv/barrier_completion_tracker_core.sv]
// Barrier completion tracker: request, acknowledge and flush control.
// Request or flush: result registered on the beat; 1 item per cycle unless stalled.
// Acknowledge retiring k entries (1..16): k beats, the first registered in retire state,
// then 1 per cycle unless stalled, as the head cell shifts out; next item taken after.
// Output register frees on the response beat. Reset (synchronous) empties the queue,
// zeroes the barrier counter and last requested numbers, types_in_use returns to 1.
module barrier_completion_tracker_core (
   input logic      clock,
   input logic      reset,
   bcc_req_if.sink  req,
   bcc_rsp_if.source rsp,
   bcc_csr_if.sink  csr
);
   import bcc_pkg::*;

   state_type           state_ff;
   state_type           state_in;
   logic [3:0]          types_ff;
   logic [3:0]          types_in;
   logic [63:0]         counter_ff;
   logic [63:0]         counter_in;
   logic [63:0]         last_req_ff [NUM_TYPES];
   logic [63:0]         last_req_in [NUM_TYPES];
   logic [63:0]         ack_ff;
   logic [63:0]         ack_in;
   logic [RETIRE_W-1:0] n_ff;
   logic [RETIRE_W-1:0] n_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   queue_ctl_type       qctl;
   entry_type           push_entry;
   entry_type           head;
   entry_type           second;
   logic [COUNT_W-1:0]  count;

   logic                out_free;
   logic                req_beat;
   logic                type_ok;
   logic [63:0]         last_sel;
   logic                eligible;
   logic                final_retire;
   logic [TYPE_IDX_W-1:0] tidx;

   bcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (qctl),
      .push_entry (push_entry),
      .head       (head),
      .second     (second),
      .count      (count)
   );

   // handshake and decode
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign req_beat = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign tidx = req.data.type_id[TYPE_IDX_W-1:0];
   assign type_ok = ({1'b0, req.data.type_id} < types_ff)
                 && (32'(req.data.type_id) < NUM_TYPES);
   assign last_sel = last_req_ff[tidx];

   // retire decision at the head of the queue
   assign eligible = (count != '0) && (ack_ff >= head.tag);
   assign final_retire = (count == COUNT_W'(1)) || (n_ff == RETIRE_W'(MAX_RESULTS - 1))
                      || (ack_ff < second.tag);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req.data.func == FUNC_ACK)) begin
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if (out_free && (!eligible || final_retire)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      types_in     = types_ff;
      counter_in   = counter_ff;
      last_req_in  = last_req_ff;
      ack_in       = ack_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      qctl         = '0;
      push_entry.type_id = req.data.type_id;
      push_entry.seqno   = req.data.app_seqno;
      push_entry.tag     = counter_ff + 64'd1;

      if (csr.valid) begin
         types_in = csr.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               rsp_data_in.last        = 1'b1;
               rsp_data_in.type_out    = req.data.type_id;
               rsp_data_in.seqno_out   = req.data.app_seqno;
               rsp_data_in.barrier_tag = counter_ff;
               unique case (req.data.func)
                  FUNC_REQUEST: begin
                     rsp_valid_in = 1'b1;
                     priority if (!type_ok) begin
                        rsp_data_in.status    = STAT_BAD_TYPE;
                        rsp_data_in.type_out  = '0;
                        rsp_data_in.seqno_out = '0;
                     end else if (req.data.app_seqno == last_sel) begin
                        rsp_data_in.status = STAT_DUPLICATE;
                     end else if (count >= COUNT_W'(QUEUE_DEPTH)) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        rsp_data_in.status      = STAT_QUEUED;
                        rsp_data_in.barrier_tag = counter_ff + 64'd1;
                        counter_in              = counter_ff + 64'd1;
                        last_req_in[tidx]       = req.data.app_seqno;
                        qctl.push               = 1'b1;
                     end
                  end
                  FUNC_ACK: begin
                     ack_in = req.data.ack_tag;
                     n_in   = '0;
                  end
                  FUNC_FLUSH: begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.status      = STAT_FLUSHED;
                     rsp_data_in.type_out    = '0;
                     rsp_data_in.seqno_out   = '0;
                     rsp_data_in.barrier_tag = '0;
                     counter_in              = '0;
                     qctl.flush              = 1'b1;
                  end
                  FUNC_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RETIRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (eligible) begin
                  rsp_data_in.status      = STAT_RETIRED;
                  rsp_data_in.type_out    = head.type_id;
                  rsp_data_in.seqno_out   = head.seqno;
                  rsp_data_in.barrier_tag = head.tag;
                  rsp_data_in.last        = final_retire;
                  qctl.pop                = 1'b1;
                  n_in                    = n_ff + RETIRE_W'(1);
               end else begin
                  rsp_data_in.status      = STAT_NONE;
                  rsp_data_in.type_out    = '0;
                  rsp_data_in.seqno_out   = '0;
                  rsp_data_in.barrier_tag = counter_ff;
                  rsp_data_in.last        = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         types_ff     <= 4'd1;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         for (int i = 0; i < NUM_TYPES; i++) begin
            last_req_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         types_ff     <= types_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         last_req_ff  <= last_req_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff      <= ack_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_retire_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RETIRE && rsp_valid_in && !(rsp_valid_ff && !rsp.ready)
       && rsp_data_in.last) |=> (state_ff == ST_IDLE))
      else $error("retire run did not end on its last beat");
   a_retire_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RETIRE) |-> (32'(n_ff) < MAX_RESULTS))
      else $error("too many retirements for one acknowledge");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(rsp_data_ff))
      else $error("pending response overwritten");
   a_push_tags_counter: assert property (@(posedge clock) disable iff (reset)
      qctl.push |=> (counter_ff == $past(counter_ff) + 64'd1))
      else $error("queued entry without counter step");
`endif

endmodule
